// ===== rtl/core/spr_pkg.sv =====
// shared types and constants of the seek point resolver
package spr_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned SAMPLE_W = 36;
  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OPC_W    = 3;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned          CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b1;

  // operation codes on the request channel
  localparam logic [OPC_W-1:0] OPC_LOAD  = 3'd0;
  localparam logic [OPC_W-1:0] OPC_START = 3'd1;
  localparam logic [OPC_W-1:0] OPC_FRAME = 3'd2;
  localparam logic [OPC_W-1:0] OPC_ERROR = 3'd3;
  localparam logic [OPC_W-1:0] OPC_READ  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_START = 3'd2,
    OP_FRAME = 3'd3,
    OP_ERROR = 3'd4,
    OP_READ  = 3'd5
  } cmd_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RDATA = 4'b0010,
    ST_WREQ  = 4'b0100,
    ST_WCMP  = 4'b1000
  } state_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [IDX_W-1:0]      entry_index;
    logic [SAMPLE_W-1:0]   target_sample;
    logic [SIZE_W-1:0]     frame_block_size;
    logic [OFFSET_W-1:0]   frame_end_offset;
  } cmd_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   entry_sample;
    logic [OFFSET_W-1:0]   entry_offset;
    logic [SIZE_W-1:0]     entry_size;
  } entry_t;

  typedef struct packed {
    logic                  abort_flag;
    logic [SAMPLE_W-1:0]   entry_sample;
    logic [OFFSET_W-1:0]   entry_offset;
    logic [SIZE_W-1:0]     entry_frame_size;
  } result_t;

endpackage

// ===== rtl/core/spr_if.sv =====
// request and response channels of the seek point resolver
interface spr_req_if;
  logic                          valid;
  logic                          ready;
  logic [spr_pkg::OPC_W-1:0]     operation;
  logic [spr_pkg::IDX_W-1:0]     entry_index;
  logic [spr_pkg::SAMPLE_W-1:0]  target_sample;
  logic [spr_pkg::SIZE_W-1:0]    frame_block_size;
  logic [spr_pkg::OFFSET_W-1:0]  frame_end_offset;

  modport source (
    output valid, operation, entry_index, target_sample, frame_block_size, frame_end_offset,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, target_sample, frame_block_size, frame_end_offset,
    output ready
  );
endinterface

interface spr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          abort_flag;
  logic [spr_pkg::SAMPLE_W-1:0]  entry_sample;
  logic [spr_pkg::OFFSET_W-1:0]  entry_offset;
  logic [spr_pkg::SIZE_W-1:0]    entry_frame_size;

  modport source (
    output valid, abort_flag, entry_sample, entry_offset, entry_frame_size,
    input  ready
  );
  modport sink (
    input  valid, abort_flag, entry_sample, entry_offset, entry_frame_size,
    output ready
  );
endinterface

// ===== rtl/core/spr_ram.sv =====
// generic single write port ram with registered read
module spr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/spr_front.sv =====
// front end: accepts request beats, classifies the operation, queues commands
module spr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  spr_req_if.sink           req_i,
  output spr_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i
);

  localparam int unsigned PTR_W = $clog2(spr_pkg::QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(spr_pkg::QUEUE_DEPTH + 1);

  spr_pkg::cmd_t      queue_q [spr_pkg::QUEUE_DEPTH];
  spr_pkg::cmd_t      cmd_in;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               push;
  logic               pop;

  always_comb begin
    cmd_in.entry_index      = req_i.entry_index;
    cmd_in.target_sample    = req_i.target_sample;
    cmd_in.frame_block_size = req_i.frame_block_size;
    cmd_in.frame_end_offset = req_i.frame_end_offset;
    unique case (req_i.operation)
      spr_pkg::OPC_LOAD:  cmd_in.kind = spr_pkg::OP_LOAD;
      spr_pkg::OPC_START: cmd_in.kind = spr_pkg::OP_START;
      spr_pkg::OPC_FRAME: cmd_in.kind = spr_pkg::OP_FRAME;
      spr_pkg::OPC_ERROR: cmd_in.kind = spr_pkg::OP_ERROR;
      spr_pkg::OPC_READ:  cmd_in.kind = spr_pkg::OP_READ;
      default:            cmd_in.kind = spr_pkg::OP_NONE;
    endcase
  end

  assign req_i.ready = (count_q != QCNT_W'(spr_pkg::QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(spr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(spr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(spr_pkg::QUEUE_DEPTH))
    else $error("command queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("command queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ===== rtl/core/spr_back.sv =====
// back end: executes queued commands against the point table and drives results
module spr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spr_pkg::cmd_t                 cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  logic                          cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spr_pkg::OFFSET_W-1:0]  cfg_wdata_i,
  spr_rsp_if.source                     rsp_o
);

  localparam int unsigned ENTRY_W = $bits(spr_pkg::entry_t);

  spr_pkg::state_e                state_q, state_d;
  logic [spr_pkg::OFFSET_W-1:0]   audio_start_q;
  logic [spr_pkg::CNT_W-1:0]      point_count_q;
  logic [spr_pkg::CNT_W-1:0]      next_entry_q, next_entry_d;
  logic [spr_pkg::SAMPLE_W-1:0]   samples_q, samples_d;
  logic [spr_pkg::OFFSET_W-1:0]   prev_end_q, prev_end_d;
  logic                           err_q, err_d;
  logic [spr_pkg::CNT_W-1:0]      idx_q, idx_d;
  logic                           out_valid_q, out_valid_d;
  spr_pkg::result_t               res_q, res_d;

  logic [spr_pkg::SAMPLE_W-1:0]   first_q, first_d;
  logic [spr_pkg::SAMPLE_W:0]     past_q, past_d;
  logic [spr_pkg::OFFSET_W-1:0]   rel_q, rel_d;
  logic [spr_pkg::SIZE_W-1:0]     bsize_q, bsize_d;
  logic [spr_pkg::OFFSET_W-1:0]   end_q, end_d;
  logic [spr_pkg::CNT_W-1:0]      limit_q, limit_d;

  logic                           ram_we;
  logic [spr_pkg::IDX_W-1:0]      ram_waddr;
  spr_pkg::entry_t                ram_wdata;
  logic [spr_pkg::IDX_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]             ram_rdata;
  spr_pkg::entry_t                rd_entry;
  logic                           walk_done;

  spr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (spr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = spr_pkg::entry_t'(ram_rdata);

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.abort_flag       = res_q.abort_flag;
  assign rsp_o.entry_sample     = res_q.entry_sample;
  assign rsp_o.entry_offset     = res_q.entry_offset;
  assign rsp_o.entry_frame_size = res_q.entry_frame_size;

  always_comb begin
    state_d      = state_q;
    next_entry_d = next_entry_q;
    samples_d    = samples_q;
    prev_end_d   = prev_end_q;
    err_d        = err_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    res_d        = res_q;
    first_d      = first_q;
    past_d       = past_q;
    rel_d        = rel_q;
    bsize_d      = bsize_q;
    end_d        = end_q;
    limit_d      = limit_q;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[spr_pkg::IDX_W-1:0];
    ram_wdata    = '{entry_sample: first_q, entry_offset: rel_q, entry_size: bsize_q};
    ram_raddr    = idx_q[spr_pkg::IDX_W-1:0];
    walk_done    = 1'b0;

    unique case (state_q)
      spr_pkg::ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          res_d     = '0;
          unique case (cmd_i.kind)
            spr_pkg::OP_LOAD: begin
              ram_we      = 1'b1;
              ram_waddr   = cmd_i.entry_index;
              ram_wdata   = '{entry_sample: cmd_i.target_sample, entry_offset: '0,
                              entry_size: '0};
              out_valid_d = 1'b1;
            end
            spr_pkg::OP_START: begin
              next_entry_d = '0;
              samples_d    = '0;
              prev_end_d   = audio_start_q;
              err_d        = 1'b0;
              out_valid_d  = 1'b1;
            end
            spr_pkg::OP_FRAME: begin
              if (err_q) begin
                res_d.abort_flag = 1'b1;
                out_valid_d      = 1'b1;
              end else begin
                first_d = samples_q;
                past_d  = {1'b0, samples_q} + (spr_pkg::SAMPLE_W + 1)'(cmd_i.frame_block_size);
                rel_d   = prev_end_q - audio_start_q;
                bsize_d = cmd_i.frame_block_size;
                end_d   = cmd_i.frame_end_offset;
                limit_d = (point_count_q > spr_pkg::CNT_W'(spr_pkg::TABLE_DEPTH)) ?
                          spr_pkg::CNT_W'(spr_pkg::TABLE_DEPTH) : point_count_q;
                idx_d   = next_entry_q;
                state_d = spr_pkg::ST_WREQ;
              end
            end
            spr_pkg::OP_ERROR: begin
              err_d       = 1'b1;
              out_valid_d = 1'b1;
            end
            spr_pkg::OP_READ: begin
              ram_raddr = cmd_i.entry_index;
              state_d   = spr_pkg::ST_RDATA;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      spr_pkg::ST_RDATA: begin
        res_d.abort_flag       = 1'b0;
        res_d.entry_sample     = rd_entry.entry_sample;
        res_d.entry_offset     = rd_entry.entry_offset;
        res_d.entry_frame_size = rd_entry.entry_size;
        out_valid_d            = 1'b1;
        state_d                = spr_pkg::ST_IDLE;
      end
      spr_pkg::ST_WREQ: begin
        if (idx_q < limit_q) begin
          state_d = spr_pkg::ST_WCMP;
        end else begin
          walk_done = 1'b1;
        end
      end
      spr_pkg::ST_WCMP: begin
        if ({1'b0, rd_entry.entry_sample} >= past_q) begin
          walk_done = 1'b1;
        end else begin
          ram_we  = (rd_entry.entry_sample >= first_q);
          idx_d   = idx_q + 1'b1;
          state_d = spr_pkg::ST_WREQ;
        end
      end
      default: begin
        state_d = spr_pkg::ST_IDLE;
      end
    endcase

    if (walk_done) begin
      samples_d    = past_q[spr_pkg::SAMPLE_W] ? '1 : past_q[spr_pkg::SAMPLE_W-1:0];
      prev_end_d   = end_q;
      next_entry_d = idx_q;
      res_d        = '0;
      out_valid_d  = 1'b1;
      state_d      = spr_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= spr_pkg::ST_IDLE;
      audio_start_q <= '0;
      point_count_q <= '0;
      next_entry_q  <= '0;
      samples_q     <= '0;
      prev_end_q    <= '0;
      err_q         <= 1'b0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_entry_q <= next_entry_d;
      samples_q    <= samples_d;
      prev_end_q   <= prev_end_d;
      err_q        <= err_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          spr_pkg::CFG_AUDIO_START: audio_start_q <= cfg_wdata_i;
          spr_pkg::CFG_POINT_COUNT: point_count_q <= cfg_wdata_i[spr_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    first_q <= first_d;
    past_q  <= past_d;
    rel_q   <= rel_d;
    bsize_q <= bsize_d;
    end_q   <= end_d;
    limit_q <= limit_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !out_valid_q)
    else $error("command taken while a result still waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spr_pkg::ST_WCMP) |-> (idx_q < limit_q))
    else $error("walk compare beyond the table limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == spr_pkg::ST_IDLE || state_q == spr_pkg::ST_WCMP))
    else $error("table write outside load or walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.abort_flag) |->
      (res_q.entry_sample == '0 && res_q.entry_offset == '0 && res_q.entry_frame_size == '0))
    else $error("abort result carries entry data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spr_pkg::ST_IDLE) |-> !out_valid_q)
    else $error("result pending while a command runs");

endmodule

// ===== rtl/core/seek_point_resolver.sv =====
// seek point resolver top level
// Request beats go into a two-entry command queue, so the requester is only held
// off when two commands are waiting; the executor takes one command at a time
// from it and hands each result to an output register, one result per request.
// Load, start, decode error and unused codes finish straight from idle; a read
// goes through the table read register, and a frame walks the table from the
// next entry until an entry lies past the frame or the walk reaches the point
// count, capped at the table depth; a frame after a decode error aborts at once.
// The walk is paced by the table memory, which has one read port with a
// registered read. A new command starts only once the previous result has been
// taken. Table entries hold nothing defined until they are loaded; configuration
// must be written only while the block is idle; the block does not enforce this.
module seek_point_resolver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  spr_req_if.sink                       req_i,
  spr_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spr_pkg::OFFSET_W-1:0]  cfg_wdata_i
);

  spr_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  spr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  spr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

endmodule
